// File: rtl/indexed_min_heap_priority_queue_macros.svh
`ifndef INDEXED_MIN_HEAP_PRIORITY_QUEUE_MACROS_SVH
`define INDEXED_MIN_HEAP_PRIORITY_QUEUE_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define IMHPQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("imhpq check failed");

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define IMHPQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("imhpq check failed");

`endif

// File: rtl/imhpq_pkg.sv
package imhpq_pkg;

  localparam int IMH_CAPACITY  = 1024;
  localparam int IMH_KEY_WIDTH = 31;

  localparam logic [1:0] OP_INIT = 2'd0;
  localparam logic [1:0] OP_SET  = 2'd1;
  localparam logic [1:0] OP_XT   = 2'd2;
  localparam logic [1:0] OP_PEEK = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;
  localparam logic [1:0] ST_BADID  = 2'd3;

  typedef enum logic [4:0] {
    CMD_NOP,
    CMD_CAPTURE,
    CMD_CLR_BEGIN,
    CMD_INIT_BEGIN,
    CMD_SWEEP,
    CMD_LOOKUP,
    CMD_LOOKED,
    CMD_SET_BEGIN,
    CMD_UP_CHK,
    CMD_UP_RD1,
    CMD_UP_RD2,
    CMD_DN_CHK,
    CMD_DN_RD1,
    CMD_DN_RD2,
    CMD_PLACE,
    CMD_XT_RD1,
    CMD_XT_RD2,
    CMD_XT_UPD,
    CMD_OUT
  } cmd_e;

  typedef struct packed {
    logic [1:0] op;
    logic [1:0] st;
    logic       sweep_last;
    logic       pos_zero;
    logic       up_root;
    logic       up_stop;
    logic       dn_end;
    logic       dn_stop;
    logic       cnt_one;
  } stat_t;

  // 0x7f in every byte, cut to kw bits
  function automatic logic [63:0] key_inf(input int kw);
    logic [63:0] v;
    v = '0;
    for (int b = 0; b < 64; b++) begin
      if (b < kw && (b % 8) != 7) v[b] = 1'b1;
    end
    return v;
  endfunction

endpackage

// File: rtl/indexed_min_heap_priority_queue.sv
// Indexed binary min-heap over item ids 1..min(item_count, CAPACITY), with a key store,
// a position map and a slot array held in single-write memories of CAPACITY+1 words.
// One word is worked on at a time; a new word is taken when the previous one has reached
// the output register. After reset the input stays stalled while the key store and
// position map are swept; init runs a like sweep. Set key moves its entry up and then
// down the heap, extract moves the last entry down from the root: each heap level costs
// a slot read, a key read and a write-back on the memory ports.
module indexed_min_heap_priority_queue
  import imhpq_pkg::*;
#(
  parameter int CAPACITY  = imhpq_pkg::IMH_CAPACITY,
  parameter int KEY_WIDTH = imhpq_pkg::IMH_KEY_WIDTH,
  parameter int IDW       = $clog2(CAPACITY + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           opcode_i,
  input  logic [IDW-1:0]       item_id_i,
  input  logic [KEY_WIDTH-1:0] new_key_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [IDW-1:0]       out_item_o,
  output logic [KEY_WIDTH-1:0] out_key_o,
  output logic [IDW-1:0]       out_position_o,
  output logic [IDW-1:0]       entries_left_o,
  output logic [1:0]           status_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

`include "indexed_min_heap_priority_queue_macros.svh"

  cmd_e           cmd;
  stat_t          stat;
  logic [IDW-1:0] item_count_q;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? '0 : 32'(item_count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_count_q <= IDW'(CAPACITY);
    end else if (psel && penable && pwrite && !paddr[2]) begin
      item_count_q <= pwdata[IDW-1:0];
    end
  end

  imhpq_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .out_valid_o,
    .out_stall_i,
    .cmd_o  (cmd),
    .stat_i (stat)
  );

  imhpq_dp #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH),
    .IDW       (IDW)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i          (cmd),
    .stat_o         (stat),
    .item_count_i   (item_count_q),
    .opcode_i,
    .item_id_i,
    .new_key_i,
    .out_item_o,
    .out_key_o,
    .out_position_o,
    .entries_left_o,
    .status_o
  );

  `IMHPQ_ASSERT_NEXT(a_one_word_in_flight, in_valid_i && !in_stall_o, in_stall_o)
  `IMHPQ_ASSERT_NOW(a_empty_leaves_none, out_valid_o && status_o == ST_EMPTY,
                    entries_left_o == '0 && out_item_o == '0)
  `IMHPQ_ASSERT_NOW(a_count_in_range, out_valid_o, entries_left_o <= IDW'(CAPACITY))

endmodule

// File: rtl/imhpq_dp.sv
module imhpq_dp #(
  parameter int CAPACITY  = 1024,
  parameter int KEY_WIDTH = 31,
  parameter int IDW       = $clog2(CAPACITY + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  imhpq_pkg::cmd_e      cmd_i,
  output imhpq_pkg::stat_t     stat_o,
  input  logic [IDW-1:0]       item_count_i,
  input  logic [1:0]           opcode_i,
  input  logic [IDW-1:0]       item_id_i,
  input  logic [KEY_WIDTH-1:0] new_key_i,
  output logic [IDW-1:0]       out_item_o,
  output logic [KEY_WIDTH-1:0] out_key_o,
  output logic [IDW-1:0]       out_position_o,
  output logic [IDW-1:0]       entries_left_o,
  output logic [1:0]           status_o
);
  import imhpq_pkg::*;

  localparam int SW = IDW + 1;
  localparam logic [KEY_WIDTH-1:0] KeyInf = KEY_WIDTH'(key_inf(KEY_WIDTH));
  localparam logic [IDW-1:0] CapId = IDW'(CAPACITY);
  localparam logic [IDW-1:0] OneId = IDW'(1);

  logic [IDW-1:0]       ho_mem [0:CAPACITY];
  logic [IDW-1:0]       ip_mem [0:CAPACITY];
  logic [KEY_WIDTH-1:0] ks_mem [0:CAPACITY];

  logic [IDW-1:0]       ho_rd_a, ho_rd_b, ip_rd;
  logic [KEY_WIDTH-1:0] ks_rd_a, ks_rd_b;
  logic [IDW-1:0]       ho_ra, ho_rb, ks_ra, ks_rb, ip_ra;
  logic                 ho_we, ip_we, ks_we;
  logic [IDW-1:0]       ho_wa, ho_wd, ip_wa, ip_wd, ks_wa;
  logic [KEY_WIDTH-1:0] ks_wd;

  logic [1:0]           op_q;
  logic [IDW-1:0]       id_q, cnt_q, idx_q, sweep_n_q, slot_q, it_q, p_q, l_q, r_q;
  logic [KEY_WIDTH-1:0] nk_q, key_q;
  logic [IDW-1:0]       res_item_q, res_pos_q;
  logic [KEY_WIDTH-1:0] res_key_q;
  logic [1:0]           res_st_q;

  logic [IDW-1:0]       n_load;
  logic                 bad_id;
  logic [SW-1:0]        ch, ch_nx;
  logic                 ch_lt, dn_end, pick_r, dn_stop, up_stop;
  logic [IDW-1:0]       c_item, c_slot;
  logic [KEY_WIDTH-1:0] c_key;

  assign n_load  = (item_count_i > CapId) ? CapId : item_count_i;
  assign bad_id  = (item_id_i == '0) || (item_id_i > n_load);
  assign ch      = {slot_q, 1'b0};
  assign ch_nx   = ch + SW'(1);
  assign ch_lt   = ch < {1'b0, cnt_q};
  assign dn_end  = (slot_q >= cnt_q) || (ch > {1'b0, cnt_q});
  assign pick_r  = ch_lt && (ks_rd_b < ks_rd_a);
  assign c_item  = pick_r ? r_q : l_q;
  assign c_key   = pick_r ? ks_rd_b : ks_rd_a;
  assign c_slot  = pick_r ? ch_nx[IDW-1:0] : ch[IDW-1:0];
  assign dn_stop = c_key >= key_q;
  assign up_stop = ks_rd_a <= key_q;

  always_comb begin
    stat_o.op         = op_q;
    stat_o.st         = res_st_q;
    stat_o.sweep_last = idx_q == CapId;
    stat_o.pos_zero   = ip_rd == '0;
    stat_o.up_root    = slot_q == OneId;
    stat_o.up_stop    = up_stop;
    stat_o.dn_end     = dn_end;
    stat_o.dn_stop    = dn_stop;
    stat_o.cnt_one    = cnt_q == OneId;
  end

  always_comb begin
    ho_ra = '0;
    ho_rb = '0;
    ks_ra = '0;
    ks_rb = '0;
    ip_ra = '0;
    ho_we = 1'b0;
    ho_wa = '0;
    ho_wd = '0;
    ip_we = 1'b0;
    ip_wa = '0;
    ip_wd = '0;
    ks_we = 1'b0;
    ks_wa = '0;
    ks_wd = '0;
    unique case (cmd_i)
      CMD_SWEEP: begin
        ho_we = 1'b1;
        ho_wa = idx_q;
        ho_wd = idx_q;
        ip_we = 1'b1;
        ip_wa = idx_q;
        ip_wd = (idx_q != '0 && idx_q <= sweep_n_q) ? idx_q : '0;
        ks_we = 1'b1;
        ks_wa = idx_q;
        ks_wd = KeyInf;
      end
      CMD_LOOKUP: begin
        ks_ra = id_q;
        ip_ra = id_q;
      end
      CMD_SET_BEGIN: begin
        ks_we = 1'b1;
        ks_wa = id_q;
        ks_wd = nk_q;
      end
      CMD_UP_CHK: ho_ra = slot_q >> 1;
      CMD_UP_RD1: ks_ra = ho_rd_a;
      CMD_UP_RD2: begin
        ho_we = !up_stop;
        ho_wa = slot_q;
        ho_wd = p_q;
        ip_we = !up_stop;
        ip_wa = p_q;
        ip_wd = slot_q;
      end
      CMD_DN_CHK: begin
        ho_ra = dn_end ? '0 : ch[IDW-1:0];
        ho_rb = dn_end ? '0 : (ch_lt ? ch_nx[IDW-1:0] : ch[IDW-1:0]);
      end
      CMD_DN_RD1: begin
        ks_ra = ho_rd_a;
        ks_rb = ho_rd_b;
      end
      CMD_DN_RD2: begin
        ho_we = !dn_stop;
        ho_wa = slot_q;
        ho_wd = c_item;
        ip_we = !dn_stop;
        ip_wa = c_item;
        ip_wd = slot_q;
      end
      CMD_PLACE: begin
        ho_we = 1'b1;
        ho_wa = slot_q;
        ho_wd = it_q;
        ip_we = 1'b1;
        ip_wa = it_q;
        ip_wd = slot_q;
      end
      CMD_XT_RD1: begin
        ho_ra = OneId;
        ho_rb = cnt_q;
      end
      CMD_XT_RD2: begin
        ks_ra = ho_rd_a;
        ks_rb = ho_rd_b;
      end
      CMD_XT_UPD: begin
        ho_we = 1'b1;
        ho_wa = OneId;
        ho_wd = r_q;
        ip_we = 1'b1;
        ip_wa = l_q;
        ip_wd = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ho_we) ho_mem[ho_wa] <= ho_wd;
    ho_rd_a <= ho_mem[ho_ra];
    ho_rd_b <= ho_mem[ho_rb];
  end

  always_ff @(posedge clk_i) begin
    if (ip_we) ip_mem[ip_wa] <= ip_wd;
    ip_rd <= ip_mem[ip_ra];
  end

  always_ff @(posedge clk_i) begin
    if (ks_we) ks_mem[ks_wa] <= ks_wd;
    ks_rd_a <= ks_mem[ks_ra];
    ks_rd_b <= ks_mem[ks_rb];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      if (cmd_i == CMD_SWEEP && idx_q == CapId) cnt_q <= sweep_n_q;
      else if (cmd_i == CMD_XT_UPD) cnt_q <= cnt_q - OneId;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i)
      CMD_CAPTURE: begin
        op_q       <= opcode_i;
        id_q       <= item_id_i;
        nk_q       <= new_key_i;
        res_item_q <= '0;
        res_key_q  <= '0;
        res_pos_q  <= '0;
        if (opcode_i == OP_XT && cnt_q == '0) res_st_q <= ST_EMPTY;
        else if ((opcode_i == OP_SET || opcode_i == OP_PEEK) && bad_id) res_st_q <= ST_BADID;
        else res_st_q <= ST_OK;
      end
      CMD_CLR_BEGIN: begin
        idx_q     <= '0;
        sweep_n_q <= '0;
      end
      CMD_INIT_BEGIN: begin
        idx_q     <= '0;
        sweep_n_q <= n_load;
      end
      CMD_SWEEP: idx_q <= idx_q + OneId;
      CMD_LOOKED: begin
        res_item_q <= id_q;
        res_key_q  <= ks_rd_a;
        res_pos_q  <= ip_rd;
        res_st_q   <= (ip_rd == '0) ? ST_ABSENT : ST_OK;
      end
      CMD_SET_BEGIN: begin
        slot_q    <= res_pos_q;
        it_q      <= id_q;
        key_q     <= nk_q;
        res_key_q <= nk_q;
      end
      CMD_UP_RD1: p_q <= ho_rd_a;
      CMD_UP_RD2: if (!up_stop) slot_q <= slot_q >> 1;
      CMD_DN_RD1: begin
        l_q <= ho_rd_a;
        r_q <= ho_rd_b;
      end
      CMD_DN_RD2: if (!dn_stop) slot_q <= c_slot;
      CMD_PLACE: if (op_q == OP_SET) res_pos_q <= slot_q;
      CMD_XT_RD2: begin
        l_q <= ho_rd_a;
        r_q <= ho_rd_b;
      end
      CMD_XT_UPD: begin
        res_item_q <= l_q;
        res_key_q  <= ks_rd_a;
        it_q       <= r_q;
        key_q      <= ks_rd_b;
        slot_q     <= OneId;
      end
      CMD_OUT: begin
        out_item_o     <= res_item_q;
        out_key_o      <= res_key_q;
        out_position_o <= res_pos_q;
        entries_left_o <= cnt_q;
        status_o       <= res_st_q;
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/imhpq_ctrl.sv
module imhpq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output imhpq_pkg::cmd_e   cmd_o,
  input  imhpq_pkg::stat_t  stat_i
);
  import imhpq_pkg::*;

  typedef enum logic [4:0] {
    S_CLR_BEGIN, S_CLR_SWEEP, S_IDLE, S_DISPATCH, S_INIT_BEGIN, S_INIT_SWEEP,
    S_LOOKUP, S_LOOKED, S_SET_BEGIN, S_UP_CHK, S_UP_RD1, S_UP_RD2, S_UP_PLACE,
    S_DN_CHK, S_DN_RD1, S_DN_RD2, S_DN_PLACE, S_XT_RD1, S_XT_RD2, S_XT_UPD, S_FIN
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = CMD_NOP;
    unique case (state_q)
      S_CLR_BEGIN: begin
        cmd_o   = CMD_CLR_BEGIN;
        state_d = S_CLR_SWEEP;
      end
      S_CLR_SWEEP: begin
        cmd_o = CMD_SWEEP;
        if (stat_i.sweep_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o   = CMD_CAPTURE;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat_i.st != ST_OK) state_d = S_FIN;
        else if (stat_i.op == OP_INIT) state_d = S_INIT_BEGIN;
        else if (stat_i.op == OP_XT) state_d = S_XT_RD1;
        else state_d = S_LOOKUP;
      end
      S_INIT_BEGIN: begin
        cmd_o   = CMD_INIT_BEGIN;
        state_d = S_INIT_SWEEP;
      end
      S_INIT_SWEEP: begin
        cmd_o = CMD_SWEEP;
        if (stat_i.sweep_last) state_d = S_FIN;
      end
      S_LOOKUP: begin
        cmd_o   = CMD_LOOKUP;
        state_d = S_LOOKED;
      end
      S_LOOKED: begin
        cmd_o = CMD_LOOKED;
        if (stat_i.op == OP_PEEK || stat_i.pos_zero) state_d = S_FIN;
        else state_d = S_SET_BEGIN;
      end
      S_SET_BEGIN: begin
        cmd_o   = CMD_SET_BEGIN;
        state_d = S_UP_CHK;
      end
      S_UP_CHK: begin
        cmd_o   = CMD_UP_CHK;
        state_d = stat_i.up_root ? S_UP_PLACE : S_UP_RD1;
      end
      S_UP_RD1: begin
        cmd_o   = CMD_UP_RD1;
        state_d = S_UP_RD2;
      end
      S_UP_RD2: begin
        cmd_o   = CMD_UP_RD2;
        state_d = stat_i.up_stop ? S_UP_PLACE : S_UP_CHK;
      end
      S_UP_PLACE: begin
        cmd_o   = CMD_PLACE;
        state_d = S_DN_CHK;
      end
      S_DN_CHK: begin
        cmd_o   = CMD_DN_CHK;
        state_d = stat_i.dn_end ? S_DN_PLACE : S_DN_RD1;
      end
      S_DN_RD1: begin
        cmd_o   = CMD_DN_RD1;
        state_d = S_DN_RD2;
      end
      S_DN_RD2: begin
        cmd_o   = CMD_DN_RD2;
        state_d = stat_i.dn_stop ? S_DN_PLACE : S_DN_CHK;
      end
      S_DN_PLACE: begin
        cmd_o   = CMD_PLACE;
        state_d = S_FIN;
      end
      S_XT_RD1: begin
        cmd_o   = CMD_XT_RD1;
        state_d = S_XT_RD2;
      end
      S_XT_RD2: begin
        cmd_o   = CMD_XT_RD2;
        state_d = S_XT_UPD;
      end
      S_XT_UPD: begin
        cmd_o   = CMD_XT_UPD;
        state_d = stat_i.cnt_one ? S_FIN : S_DN_CHK;
      end
      S_FIN: begin
        if (out_free) begin
          cmd_o   = CMD_OUT;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o == CMD_OUT) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
    else out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR_BEGIN;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: test/heap_checker.sv
`timescale 1ns / 1ps

module heap_checker
  import imhpq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  opcode_i,
  input  logic [10:0] item_id_i,
  input  logic [30:0] new_key_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [10:0] out_item_i,
  input  logic [30:0] out_key_i,
  input  logic [10:0] out_position_i,
  input  logic [10:0] entries_left_i,
  input  logic [1:0]  status_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic        pready_i,
  output int          pending_o,
  output int          errors_o
);

  localparam logic [30:0] KEY_INF = 31'h7F7F7F7F;
  localparam int CAP = IMH_CAPACITY;
  localparam logic [2:0] ADDR_ITEM_COUNT = 3'd0;

  typedef struct packed {
    logic [10:0] item;
    logic [30:0] key;
    logic [10:0] position;
    logic [10:0] left;
    logic [1:0]  st;
  } heap_word_t;

  logic [10:0] slot_item [0:CAP];
  logic [10:0] item_slot [0:CAP];
  logic [30:0] item_key  [0:CAP];
  int          live_count;
  logic [10:0] loaded_ids;
  heap_word_t  expected_words [$];

  function automatic void raise_item(int s);
    int it, up;
    it = slot_item[s];
    while (s > 1) begin
      up = s >> 1;
      if (item_key[slot_item[up]] <= item_key[it]) break;
      slot_item[s] = slot_item[up];
      item_slot[slot_item[s]] = 11'(s);
      s = up;
    end
    slot_item[s] = 11'(it);
    item_slot[it] = 11'(s);
  endfunction

  function automatic void sink_item(int s);
    int it, ch;
    it = slot_item[s];
    while (s < live_count) begin
      ch = s << 1;
      if (ch > live_count) break;
      if (ch < live_count && item_key[slot_item[ch+1]] < item_key[slot_item[ch]]) ch++;
      if (item_key[slot_item[ch]] >= item_key[it]) break;
      slot_item[s] = slot_item[ch];
      item_slot[slot_item[s]] = 11'(s);
      s = ch;
    end
    slot_item[s] = 11'(it);
    item_slot[it] = 11'(s);
  endfunction

  function automatic heap_word_t apply_word(logic [1:0] op, logic [10:0] id,
                                            logic [30:0] nk);
    heap_word_t w;
    int n, top;
    logic bad;
    w = '0;
    w.st = ST_OK;
    n = (loaded_ids > CAP) ? CAP : loaded_ids;
    bad = (id == 0) || (id > n);
    if (op == OP_INIT) begin
      for (int i = 0; i <= CAP; i++) begin
        item_key[i] = KEY_INF;
        if (i >= 1 && i <= n) begin
          slot_item[i] = 11'(i);
          item_slot[i] = 11'(i);
        end else begin
          item_slot[i] = '0;
        end
      end
      live_count = n;
    end else if (op == OP_XT) begin
      if (live_count == 0) begin
        w.st = ST_EMPTY;
      end else begin
        top = slot_item[1];
        w.item = 11'(top);
        w.key = item_key[top];
        item_slot[top] = '0;
        slot_item[1] = slot_item[live_count];
        live_count--;
        if (live_count > 0) begin
          item_slot[slot_item[1]] = 11'd1;
          sink_item(1);
        end
      end
    end else if (bad) begin
      w.st = ST_BADID;
    end else if (op == OP_SET) begin
      w.item = id;
      if (item_slot[id] == 0) begin
        w.st = ST_ABSENT;
        w.key = item_key[id];
      end else begin
        item_key[id] = nk;
        raise_item(item_slot[id]);
        sink_item(item_slot[id]);
        w.key = nk;
        w.position = item_slot[id];
      end
    end else begin
      w.item = id;
      w.key = item_key[id];
      w.position = item_slot[id];
      if (w.position == 0) w.st = ST_ABSENT;
    end
    w.left = 11'(live_count);
    return w;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    heap_word_t got, want;
    if (!rst_ni) begin
      for (int i = 0; i <= CAP; i++) begin
        slot_item[i] = '0;
        item_slot[i] = '0;
        item_key[i] = KEY_INF;
      end
      live_count = 0;
      loaded_ids = 11'd1024;
      errors_o = 0;
      expected_words.delete();
      pending_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = '{out_item_i, out_key_i, out_position_i, entries_left_i, status_i};
        if (expected_words.size() == 0) begin
          errors_o++;
          if (errors_o <= 10) $display("unexpected word: %p", got);
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            errors_o++;
            if (errors_o <= 10)
              $display("mismatch: expected %p, actual %p", want, got);
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_words.push_back(apply_word(opcode_i, item_id_i, new_key_i));
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == ADDR_ITEM_COUNT)
        loaded_ids = pwdata_i[10:0];
      pending_o = expected_words.size();
    end
  end

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import imhpq_pkg::*;

  localparam logic [30:0] KEY_INF = 31'h7F7F7F7F;
  localparam logic [2:0] ADDR_ITEM_COUNT = 3'd0;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        in_valid_i = 0;
  logic        in_stall_o;
  logic [1:0]  opcode_i = OP_INIT;
  logic [10:0] item_id_i = 0;
  logic [30:0] new_key_i = 0;
  logic        out_valid_o;
  logic        out_stall_i = 0;
  logic [10:0] out_item_o;
  logic [30:0] out_key_o;
  logic [10:0] out_position_o;
  logic [10:0] entries_left_o;
  logic [1:0]  status_o;
  logic        psel = 0;
  logic        penable = 0;
  logic        pwrite = 0;
  logic [2:0]  paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic        pready;
  int          pending;
  int          errors;
  bit          calm = 0;
  bit          long_hold = 0;
  int          span;

  indexed_min_heap_priority_queue dut (.*);

  heap_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .opcode_i, .item_id_i,
    .new_key_i, .out_valid_i(out_valid_o), .out_stall_i, .out_item_i(out_item_o),
    .out_key_i(out_key_o), .out_position_i(out_position_o),
    .entries_left_i(entries_left_o), .status_i(status_o), .psel_i(psel),
    .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr), .pwdata_i(pwdata),
    .pready_i(pready), .pending_o(pending), .errors_o(errors)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("** indexed_min_heap_priority_queue: FAILED **");
    $finish;
  end

  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        out_stall_i <= 1;
        repeat (400) @(negedge clk_i);
        out_stall_i <= 0;
        long_hold = 0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1;
        repeat ($urandom_range(1, 9)) @(negedge clk_i);
        out_stall_i <= 0;
      end
    end
  end

  task automatic send_word(logic [1:0] op, logic [10:0] id, logic [30:0] nk);
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    in_valid_i <= 1;
    opcode_i <= op;
    item_id_i <= id;
    new_key_i <= nk;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic write_item_count(logic [10:0] v);
    @(negedge clk_i);
    in_valid_i <= 0;
    while (pending != 0) @(negedge clk_i);
    psel <= 1;
    pwrite <= 1;
    paddr <= ADDR_ITEM_COUNT;
    pwdata <= {21'd0, v};
    @(negedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
  endtask

  function automatic logic [30:0] pick_key();
    case ($urandom_range(0, 5))
      0: return 31'd0;
      1: return 31'h7FFFFFFF;
      2: return KEY_INF;
      3: return 31'($urandom_range(0, 15));
      default: return 31'($urandom());
    endcase
  endfunction

  function automatic logic [10:0] pick_id(int n);
    case ($urandom_range(0, 19))
      0: return 11'd0;
      1: return 11'($urandom_range(0, 2047));
      default: return 11'($urandom_range(1, n + 1));
    endcase
  endfunction

  initial begin
    int n, r;
    int counts [6];
    repeat (6) @(negedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);

    send_word(OP_XT, 0, 0);
    send_word(OP_PEEK, 5, 0);
    send_word(OP_SET, 5, 31'd7);
    send_word(OP_PEEK, 0, 0);
    send_word(OP_SET, 11'd2047, 31'h7FFFFFFF);
    write_item_count(11'd4);
    send_word(OP_INIT, 0, 0);
    send_word(OP_SET, 3, 31'd0);
    send_word(OP_SET, 4, 31'h7FFFFFFF);
    send_word(OP_SET, 1, 31'd0);
    send_word(OP_SET, 2, KEY_INF);
    send_word(OP_PEEK, 4, 0);
    send_word(OP_SET, 5, 31'd1);
    send_word(OP_PEEK, 5, 0);
    send_word(OP_XT, 0, 0);
    send_word(OP_SET, 3, 31'd9);
    send_word(OP_PEEK, 3, 0);
    send_word(OP_SET, 2, 31'd0);
    send_word(OP_XT, 0, 0);
    send_word(OP_XT, 0, 0);
    send_word(OP_XT, 0, 0);
    send_word(OP_XT, 0, 0);
    send_word(OP_XT, 0, 0);
    send_word(OP_SET, 1, 31'd3);
    send_word(OP_PEEK, 2, 0);

    counts = '{11'd1024, 11'd1, 11'd2047, 0, 0, 0};
    for (int p = 3; p < 6; p++) counts[p] = $urandom_range(2, 64);
    for (int p = 0; p < 6; p++) begin
      write_item_count(11'(counts[p]));
      n = (counts[p] > 1024) ? 1024 : counts[p];
      if (p == 5) calm = 1;
      send_word(OP_INIT, 0, 0);
      span = 154;
      for (int k = 0; k < span; k++) begin
        if (p == 0 && k == 20) long_hold = 1;
        r = $urandom_range(0, 99);
        if (r < 2) send_word(OP_INIT, 0, 0);
        else if (r < 47) send_word(OP_SET, pick_id(n), pick_key());
        else if (r < 72) send_word(OP_XT, 11'($urandom_range(0, 2047)), 31'($urandom()));
        else send_word(OP_PEEK, pick_id(n), 31'($urandom()));
      end
    end

    @(negedge clk_i);
    in_valid_i <= 0;
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("** indexed_min_heap_priority_queue: PASSED **");
    end else begin
      $display("** indexed_min_heap_priority_queue: FAILED **");
    end
    $finish;
  end

endmodule
